[hdl/efr_pkg.sv]
// Shared types, constants and register indexes of the edge interval frame receiver.
package efr_pkg;

	localparam int INTERVAL_BITS_DEF = 16;
	localparam int BITS_PER_BYTE     = 8;
	localparam int QUEUE_DEPTH       = 2;
	localparam int CFG_DATA_W        = 15;
	localparam int CFG_INDEX_W       = 3;
	localparam int OUT_TDATA_W       = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_BIT_PERIOD  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_JITTER_LOW  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_JITTER_HIGH = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BYTES = 3'd5;

	localparam logic [14:0] RST_BIT_PERIOD  = 15'd400;
	localparam logic [14:0] RST_JITTER_LOW  = 15'd20;
	localparam logic [14:0] RST_JITTER_HIGH = 15'd20;
	localparam logic [7:0]  RST_PREAMBLE    = 8'd170;
	localparam logic [7:0]  RST_DELIMITER   = 8'd126;
	localparam logic [7:0]  RST_FRAME_BYTES = 8'd16;

	typedef enum logic [1:0] {
		CLS_HALF,
		CLS_ONE,
		CLS_ERR
	} cls_t;

	typedef struct packed {
		logic [14:0] bit_period;
		logic [14:0] jitter_low;
		logic [14:0] jitter_high;
		logic [7:0]  preamble_value;
		logic [7:0]  delimiter_value;
		logic [7:0]  frame_bytes;
	} cfg_t;

	typedef struct packed {
		logic       bit_valid;
		logic       bit_value;
		logic       pulse_error;
		logic       busy_raise;
		logic       byte_valid;
		logic [7:0] byte_value;
		logic [7:0] byte_index;
		logic       frame_end;
	} res_t;

endpackage

[hdl/efr_front.sv]
// Front end: classifies each interval against the half and full bit windows.
module efr_front import efr_pkg::*; #(
	parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
	input  logic                     s_valid,
	input  logic [INTERVAL_BITS-1:0] interval,
	input  cfg_t                     cfg,
	input  logic                     q_full,
	output logic                     s_ready,
	output logic                     push,
	output cls_t                     cls
);

	localparam int CMP_W = (INTERVAL_BITS > 16) ? INTERVAL_BITS : 16;

	logic [14:0]      half_p;
	logic [14:0]      low_thr;
	logic [14:0]      three_q;
	logic [15:0]      high_thr;
	logic [CMP_W-1:0] t_ext;

	always_comb begin
		half_p   = {1'b0, cfg.bit_period[14:1]};
		// A low threshold that would go negative is held at zero.
		low_thr  = (half_p > cfg.jitter_low) ? (half_p - cfg.jitter_low) : 15'd0;
		three_q  = cfg.bit_period - {2'b00, cfg.bit_period[14:2]};
		high_thr = {1'b0, cfg.bit_period} + {1'b0, cfg.jitter_high};
		t_ext    = CMP_W'(interval);
		if (t_ext >= CMP_W'(low_thr) && t_ext < CMP_W'(three_q)) begin
			cls = CLS_HALF;
		end else if (t_ext >= CMP_W'(three_q) && t_ext <= CMP_W'(high_thr)) begin
			cls = CLS_ONE;
		end else begin
			cls = CLS_ERR;
		end
	end

	assign s_ready = !q_full;
	assign push    = s_valid && !q_full;

endmodule

[hdl/efr_queue.sv]
// Short queue of interval classes between the front end and the decoder.
module efr_queue import efr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cls_t  push_cls,
	input  logic  pop,
	output logic  full,
	output logic  not_empty,
	output cls_t  head_cls
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cls_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_cls  = entry_q[rd_ptr_q];

endmodule

[hdl/efr_back.sv]
// Back end: bit decoder, preamble and delimiter hunt, byte framing and result register.
module efr_back import efr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_not_empty,
	input  cls_t head_cls,
	input  cfg_t cfg,
	input  logic m_ready,
	output logic pop,
	output logic m_valid,
	output res_t res
);

	logic       half_q;
	logic [7:0] shift_q;
	logic [3:0] bit_cnt_q;
	logic [7:0] byte_cnt_q;
	logic       in_frame_q;
	logic       out_valid_q;
	res_t       res_q;

	logic       half_d;
	logic [7:0] shift_d;
	logic [3:0] bit_cnt_d;
	logic [7:0] byte_cnt_d;
	logic       in_frame_d;
	res_t       res_d;

	assign pop = q_not_empty && (!out_valid_q || m_ready);

	always_comb begin
		half_d     = half_q;
		shift_d    = shift_q;
		bit_cnt_d  = bit_cnt_q;
		byte_cnt_d = byte_cnt_q;
		in_frame_d = in_frame_q;
		res_d      = '0;

		case (head_cls)
			CLS_HALF: begin
				if (!half_q) begin
					half_d = 1'b1;
				end else begin
					half_d          = 1'b0;
					shift_d         = {shift_q[6:0], 1'b0};
					bit_cnt_d       = bit_cnt_q + 4'd1;
					res_d.bit_valid = 1'b1;
				end
			end
			CLS_ONE: begin
				half_d          = 1'b0;
				shift_d         = {shift_q[6:0], 1'b1};
				bit_cnt_d       = bit_cnt_q + 4'd1;
				res_d.bit_valid = 1'b1;
				res_d.bit_value = 1'b1;
			end
			default: begin
				half_d            = 1'b0;
				shift_d           = '0;
				bit_cnt_d         = '0;
				res_d.pulse_error = 1'b1;
			end
		endcase

		if (!in_frame_q) begin
			// The hunt compares on every edge, whether or not a bit completed.
			if (shift_d == cfg.preamble_value) begin
				res_d.busy_raise = 1'b1;
			end
			if (shift_d == cfg.delimiter_value) begin
				res_d.busy_raise = 1'b1;
				res_d.byte_valid = 1'b1;
				res_d.byte_value = shift_d;
				res_d.byte_index = byte_cnt_q;
				byte_cnt_d       = byte_cnt_q + 8'd1;
				res_d.frame_end  = (byte_cnt_d == cfg.frame_bytes);
				bit_cnt_d        = '0;
				shift_d          = '0;
				in_frame_d       = 1'b1;
			end
		end else begin
			if (bit_cnt_d == 4'(BITS_PER_BYTE)) begin
				res_d.byte_valid = 1'b1;
				res_d.byte_value = shift_d;
				res_d.byte_index = byte_cnt_q;
				byte_cnt_d       = byte_cnt_q + 8'd1;
				bit_cnt_d        = '0;
				shift_d          = '0;
			end
			// A one-byte frame closes here on the edge after its delimiter.
			if (byte_cnt_d == cfg.frame_bytes) begin
				byte_cnt_d      = '0;
				in_frame_d      = 1'b0;
				res_d.frame_end = res_d.byte_valid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= 1'b0;
			shift_q     <= '0;
			bit_cnt_q   <= '0;
			byte_cnt_q  <= '0;
			in_frame_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				half_q     <= half_d;
				shift_q    <= shift_d;
				bit_cnt_q  <= bit_cnt_d;
				byte_cnt_q <= byte_cnt_d;
				in_frame_q <= in_frame_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	assign m_valid = out_valid_q;
	assign res     = res_q;

endmodule

[hdl/edge_interval_frame_receiver.sv]
// Top level of the edge interval frame receiver: configuration registers and stream ports.
//
//  channel   direction  handshake              payload
//  s_*       in         s_tvalid / s_tready    s_tdata: interval
//  m_*       out        m_tvalid / m_tready    m_tdata: decoded bit, byte and flags; m_tlast
//  cfg_*     in         cfg_wen                cfg_index, cfg_wdata
//
// One interval is taken per clock while s_tready is high; it is queued and its result registered.
// Every interval gives exactly one result, set by the decoder stage, which updates only on a pop.
// A two-entry queue sits between classifier and decoder, so s_tready drops only when
// m_tready has been low long enough to fill it and the result register.
// Reset clears the decoder, queue pointers and output valid flag and loads the register defaults.
module edge_interval_frame_receiver import efr_pkg::*; #(
	parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// bits from 0: interval
	input  logic [((INTERVAL_BITS+7)/8)*8-1:0] s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// bits from 0: bit_valid, bit_value, pulse_error, busy_raise, byte_valid,
	// byte_value[7:0], byte_index[7:0], zero fill
	output logic [OUT_TDATA_W-1:0]              m_tdata,
	output logic                                m_tlast,
	input  logic                                cfg_wen,
	input  logic [CFG_INDEX_W-1:0]              cfg_index,
	input  logic [CFG_DATA_W-1:0]               cfg_wdata
);

	cfg_t cfg_q;
	cls_t front_cls;
	cls_t head_cls;
	logic push;
	logic pop;
	logic q_full;
	logic q_not_empty;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_period      <= RST_BIT_PERIOD;
			cfg_q.jitter_low      <= RST_JITTER_LOW;
			cfg_q.jitter_high     <= RST_JITTER_HIGH;
			cfg_q.preamble_value  <= RST_PREAMBLE;
			cfg_q.delimiter_value <= RST_DELIMITER;
			cfg_q.frame_bytes     <= RST_FRAME_BYTES;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_BIT_PERIOD:  cfg_q.bit_period      <= cfg_wdata;
				REG_JITTER_LOW:  cfg_q.jitter_low      <= cfg_wdata;
				REG_JITTER_HIGH: cfg_q.jitter_high     <= cfg_wdata;
				REG_PREAMBLE:    cfg_q.preamble_value  <= cfg_wdata[7:0];
				REG_DELIMITER:   cfg_q.delimiter_value <= cfg_wdata[7:0];
				REG_FRAME_BYTES: cfg_q.frame_bytes     <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	efr_front #(
		.INTERVAL_BITS(INTERVAL_BITS)
	) u_front (
		.s_valid  (s_tvalid),
		.interval (s_tdata[INTERVAL_BITS-1:0]),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.s_ready  (s_tready),
		.push     (push),
		.cls      (front_cls)
	);

	efr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cls  (front_cls),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_cls  (head_cls)
	);

	efr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head_cls    (head_cls),
		.cfg         (cfg_q),
		.m_ready     (m_tready),
		.pop         (pop),
		.m_valid     (m_tvalid),
		.res         (res)
	);

	assign m_tdata = {3'b000, res.byte_index, res.byte_value, res.byte_valid,
	                  res.busy_raise, res.pulse_error, res.bit_value, res.bit_valid};
	assign m_tlast = res.frame_end;

endmodule

[hdl/efr_checker.sv]
// Port-level checks of the edge interval frame receiver, bound to the top level.
module efr_checker import efr_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tlast
);

	// A result that has not been taken stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// The end of a frame is only ever marked on a delivered byte.
	a_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[4])
		else $error("frame end without a byte");

	a_bit_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[0])
		else $error("bit value set without a decoded bit");

	// A pulse error never completes a bit.
	a_err_no_bit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> !m_tdata[0])
		else $error("pulse error alongside a decoded bit");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[4] |-> (m_tdata[20:5] == 16'd0))
		else $error("byte fields set without a byte");

endmodule

bind edge_interval_frame_receiver efr_checker u_efr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
